[src/renc_pkg.sv]
// Shared types, codes and the quadrature transition table for the rotary
// encoder detent decoder. No dependencies.
package renc_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DETENT_LIMIT = 2'd0,
		CFG_DEBOUNCE_MS  = 2'd1
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_W      = 16;
	localparam int unsigned LIMIT_W         = 7;
	localparam int unsigned COUNT_W         = 8;
	localparam int unsigned TIME_W          = 32;
	localparam int unsigned EVENT_W         = 3;
	localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 7'd100;
	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET = 16'd30;

	// Result codes
	typedef enum logic [EVENT_W-1:0] {
		EV_NONE  = 3'd0,
		EV_CLICK = 3'd1,
		EV_UP    = 3'd2,
		EV_DOWN  = 3'd3,
		EV_LEFT  = 3'd4,
		EV_RIGHT = 3'd5
	} event_t;

	// Transition table states; code 7 is never entered and acts as start
	typedef enum logic [2:0] {
		ST_START     = 3'd0,
		ST_CW_FINAL  = 3'd1,
		ST_CW_BEGIN  = 3'd2,
		ST_CW_NEXT   = 3'd3,
		ST_CCW_BEGIN = 3'd4,
		ST_CCW_FINAL = 3'd5,
		ST_CCW_NEXT  = 3'd6
	} tstate_t;

	// Next state for a state and pin pair, pins = {b, a}
	function automatic tstate_t tbl_next(input tstate_t st, input logic [1:0] pins);
		tstate_t nxt;
		nxt = ST_START;
		unique case (st)
			ST_CW_FINAL: begin
				unique case (pins)
					2'b00:   nxt = ST_CW_NEXT;
					2'b10:   nxt = ST_CW_FINAL;
					default: nxt = ST_START;
				endcase
			end
			ST_CW_BEGIN: begin
				unique case (pins)
					2'b00:   nxt = ST_CW_NEXT;
					2'b01:   nxt = ST_CW_BEGIN;
					default: nxt = ST_START;
				endcase
			end
			ST_CW_NEXT: begin
				unique case (pins)
					2'b00:   nxt = ST_CW_NEXT;
					2'b01:   nxt = ST_CW_BEGIN;
					2'b10:   nxt = ST_CW_FINAL;
					default: nxt = ST_START;
				endcase
			end
			ST_CCW_BEGIN: begin
				unique case (pins)
					2'b00:   nxt = ST_CCW_NEXT;
					2'b10:   nxt = ST_CCW_BEGIN;
					default: nxt = ST_START;
				endcase
			end
			ST_CCW_FINAL: begin
				unique case (pins)
					2'b00:   nxt = ST_CCW_NEXT;
					2'b01:   nxt = ST_CCW_FINAL;
					default: nxt = ST_START;
				endcase
			end
			ST_CCW_NEXT: begin
				unique case (pins)
					2'b00:   nxt = ST_CCW_NEXT;
					2'b01:   nxt = ST_CCW_FINAL;
					2'b10:   nxt = ST_CCW_BEGIN;
					default: nxt = ST_START;
				endcase
			end
			default: begin
				// start state, and the unused code
				unique case (pins)
					2'b01:   nxt = ST_CW_BEGIN;
					2'b10:   nxt = ST_CCW_BEGIN;
					default: nxt = ST_START;
				endcase
			end
		endcase
		return nxt;
	endfunction

endpackage

[src/rotary_encoder_detent_decoder.sv]
// Rotary encoder detent decoder: transition table, saturating detent count,
// push button debounce and one-deep result register. Depends on renc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer. With
//   cmd = 0 it is an A/B pin sample: it advances the quadrature table and may
//   move the detent count; it produces no result. With cmd = 1 it is a poll:
//   it debounces the push level against now_ms and returns exactly one
//   event_res (none, click, up, down, left, right) on the output channel.
//   Configuration: cfg_we with cfg_index 0 (detent_limit) or 1 (debounce_ms)
//   writes cfg_data at the clock edge; other indexes are dropped.
// Timing:
//   Table, count and push state updates happen at the input transfer edge. A
//   poll result is valid the cycle after its transfer. One item per cycle is
//   accepted while the result register is empty or being drained, so the
//   throughput is one item per clock, set by the single result register.
// Reset:
//   arst_n clears the table to its start state, the count and push time to
//   zero, marks the button released and loads limit 100 and debounce 30.
// Stall:
//   While a result waits with out_ready low, in_ready is low; the waiting
//   result holds its value until transferred.
module rotary_encoder_detent_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic                             pin_a,
	input  logic                             pin_b,
	input  logic                             push_level,
	input  logic [renc_pkg::TIME_W-1:0]      now_ms,
	input  logic                             modifier_held,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [renc_pkg::EVENT_W-1:0]     event_res,
	input  logic                             cfg_we,
	input  logic [renc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [renc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import renc_pkg::*;

	logic [LIMIT_W-1:0]        limit_q;
	logic [CFG_DATA_W-1:0]     debounce_q;
	tstate_t                   tstate_q;
	tstate_t                   tstate_next;
	logic signed [COUNT_W-1:0] count_q;
	logic signed [COUNT_W-1:0] count_next;
	logic                      push_last_q;
	logic [TIME_W-1:0]         push_time_q;
	logic                      out_valid_q;
	event_t                    event_q;

	logic                      accept;
	logic                      step_cw;
	logic                      step_ccw;
	logic signed [COUNT_W-1:0] lim_pos;
	logic signed [COUNT_W-1:0] lim_neg;
	logic [TIME_W-1:0]         elapsed;
	logic                      push_take;
	logic                      press;
	event_t                    poll_event;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign event_res = event_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= LIMIT_RESET;
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DETENT_LIMIT: limit_q    <= cfg_data[LIMIT_W-1:0];
				CFG_DEBOUNCE_MS:  debounce_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Quadrature table: next state
	always_comb begin
		tstate_next = tbl_next(tstate_q, {pin_b, pin_a});
	end

	// Quadrature table: completed detent flags
	always_comb begin
		step_cw  = (tstate_q == ST_CW_FINAL)  && pin_a && pin_b;
		step_ccw = (tstate_q == ST_CCW_FINAL) && pin_a && pin_b;
	end

	// Push debounce
	assign elapsed   = now_ms - push_time_q;
	assign push_take = (push_level != push_last_q) &&
		(elapsed > {{(TIME_W-CFG_DATA_W){1'b0}}, debounce_q});
	assign press     = push_take && !push_level;

	// Detent count update and poll event
	assign lim_pos = $signed({1'b0, limit_q});
	assign lim_neg = -lim_pos;

	always_comb begin
		count_next = count_q;
		poll_event = EV_NONE;
		if (!cmd) begin
			if (step_cw && (count_q < lim_pos)) begin
				count_next = count_q + 8'sd1;
			end else if (step_ccw && (count_q > lim_neg)) begin
				count_next = count_q - 8'sd1;
			end
		end else if (press) begin
			poll_event = EV_CLICK;
		end else if (count_q > 8'sd0) begin
			count_next = count_q - 8'sd1;
			poll_event = modifier_held ? EV_RIGHT : EV_DOWN;
		end else if (count_q < 8'sd0) begin
			count_next = count_q + 8'sd1;
			poll_event = modifier_held ? EV_LEFT : EV_UP;
		end
	end

	// Block state, updated on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tstate_q    <= ST_START;
			count_q     <= '0;
			push_last_q <= 1'b1;
			push_time_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
			if (!cmd) begin
				tstate_q <= tstate_next;
			end else if (push_take) begin
				push_last_q <= push_level;
				push_time_q <= now_ms;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && cmd) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd) begin
			event_q <= poll_event;
		end
	end

endmodule

[src/renc_checker.sv]
// Port-level checks for the rotary encoder detent decoder, bound to the top
// level. Depends on renc_pkg.
module renc_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             cmd,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [renc_pkg::EVENT_W-1:0]     event_res
);
	import renc_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res))
		else $error("result changed while stalled");

	// Every poll transfer yields a result next cycle
	a_poll_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd |=> out_valid)
		else $error("poll gave no result");

	// A sample into an empty output produces nothing
	a_sample_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !cmd && (!out_valid || out_ready) |=> !out_valid)
		else $error("sample produced a result");

	// Empty result register never blocks input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// Result codes stay in range
	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_res <= EV_RIGHT))
		else $error("result code out of range");

endmodule

bind rotary_encoder_detent_decoder renc_checker u_renc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.cmd       (cmd),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.event_res (event_res)
);

[dv/tb_rotary_encoder_detent_decoder.sv]
// Self-checking bench for rotary_encoder_detent_decoder: drives pin samples and
// polls, tracks table state, detent count and button debounce in-line, and checks
// each event. Depends on renc_pkg and the decoder RTL.
module tb_rotary_encoder_detent_decoder;
	import renc_pkg::*;

	typedef struct packed {
		logic              cmd;
		logic              pin_a;
		logic              pin_b;
		logic              push_level;
		logic [TIME_W-1:0] now_ms;
		logic              modifier_held;
	} enc_item_t;

	localparam logic CMD_SAMPLE   = 1'b0;
	localparam logic CMD_POLL     = 1'b1;
	localparam logic BTN_PRESSED  = 1'b0;
	localparam logic BTN_RELEASED = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_3 = 2'd3;
	localparam int MAX_WAIT      = 9;
	localparam int SETTLE_CYCLES = 3;
	localparam int MAX_REPORTS   = 10;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  in_valid      = 1'b0;
	logic                  in_ready;
	logic                  cmd           = CMD_SAMPLE;
	logic                  pin_a         = 1'b0;
	logic                  pin_b         = 1'b0;
	logic                  push_level    = BTN_RELEASED;
	logic [TIME_W-1:0]     now_ms        = '0;
	logic                  modifier_held = 1'b0;
	logic                  out_valid;
	logic                  out_ready     = 1'b1;
	logic [EVENT_W-1:0]    event_res;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	rotary_encoder_detent_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.pin_a         (pin_a),
		.pin_b         (pin_b),
		.push_level    (push_level),
		.now_ms        (now_ms),
		.modifier_held (modifier_held),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_res     (event_res),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stimulus and checking bookkeeping
	enc_item_t         item_queue[$];
	event_t            pending_events[$];
	int                err_count   = 0;
	int                in_gap      = 0;
	int                out_stall   = 0;
	bit                in_taken    = 1'b0;
	bit                in_idle_on  = 1'b1;
	bit                out_idle_on = 1'b1;
	int                items_made  = 0;
	logic [TIME_W-1:0] clock_ms    = '0;

	// Decoder state as the bench tracks it
	logic [2:0]            quad_state   = ST_START;
	int                    detent_cnt   = 0;
	logic                  btn_last     = BTN_RELEASED;
	logic [TIME_W-1:0]     btn_time     = '0;
	logic [LIMIT_W-1:0]    limit_cfg    = LIMIT_RESET;
	logic [CFG_DATA_W-1:0] debounce_cfg = DEBOUNCE_RESET;

	// Next table state by [state][{b, a}]; the unused code behaves as start
	tstate_t quad_next [8][4] = '{
		'{ST_START,    ST_CW_BEGIN,  ST_CCW_BEGIN, ST_START},
		'{ST_CW_NEXT,  ST_START,     ST_CW_FINAL,  ST_START},
		'{ST_CW_NEXT,  ST_CW_BEGIN,  ST_START,     ST_START},
		'{ST_CW_NEXT,  ST_CW_BEGIN,  ST_CW_FINAL,  ST_START},
		'{ST_CCW_NEXT, ST_START,     ST_CCW_BEGIN, ST_START},
		'{ST_CCW_NEXT, ST_CCW_FINAL, ST_START,     ST_START},
		'{ST_CCW_NEXT, ST_CCW_FINAL, ST_CCW_BEGIN, ST_START},
		'{ST_START,    ST_CW_BEGIN,  ST_CCW_BEGIN, ST_START}
	};

	// Applies one item to the tracked state; returns 1 when it yields an event
	function automatic bit decode_item(input enc_item_t it, output event_t ev);
		logic [1:0]        pins;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] hold_ms;
		ev = EV_NONE;
		if (it.cmd == CMD_SAMPLE) begin
			pins = {it.pin_b, it.pin_a};
			// a detent completes when both pins go high from a final state
			if (quad_state == ST_CW_FINAL && pins == 2'b11) begin
				if (detent_cnt < int'(limit_cfg))
					detent_cnt++;
			end else if (quad_state == ST_CCW_FINAL && pins == 2'b11) begin
				if (detent_cnt > -int'(limit_cfg))
					detent_cnt--;
			end
			quad_state = quad_next[quad_state][pins];
			return 1'b0;
		end
		// button debounce, elapsed time wraps at 32 bits
		hold_ms = TIME_W'(debounce_cfg);
		elapsed = it.now_ms - btn_time;
		if (it.push_level != btn_last && elapsed > hold_ms) begin
			btn_time = it.now_ms;
			btn_last = it.push_level;
			if (it.push_level == BTN_PRESSED) begin
				ev = EV_CLICK;
				return 1'b1;
			end
		end
		// drain one stored detent toward zero
		if (detent_cnt > 0) begin
			detent_cnt--;
			ev = it.modifier_held ? EV_RIGHT : EV_DOWN;
		end else if (detent_cnt < 0) begin
			detent_cnt++;
			ev = it.modifier_held ? EV_LEFT : EV_UP;
		end
		return 1'b1;
	endfunction

	// Monitor: config writes, input transfers and result checks at the rising edge
	always @(posedge clk) begin : monitor
		event_t exp_ev;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DETENT_LIMIT: limit_cfg = cfg_data[LIMIT_W-1:0];
					CFG_DEBOUNCE_MS:  debounce_cfg = cfg_data;
					default: ;
				endcase
			end
			in_taken = in_valid && in_ready;
			if (in_taken) begin
				if (decode_item({cmd, pin_a, pin_b, push_level, now_ms, modifier_held}, exp_ev))
					pending_events.push_back(exp_ev);
			end
			if (out_valid && out_ready) begin
				out_stall = out_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
				if (pending_events.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("event_res %0d transferred with no poll outstanding", event_res);
				end else begin
					exp_ev = pending_events.pop_front();
					if (event_res !== exp_ev) begin
						err_count++;
						if (err_count <= MAX_REPORTS)
							$display("event_res mismatch: expected %0d, got %0d", exp_ev, event_res);
					end
				end
			end
		end
	end

	// Driver: input channel and result back-pressure change at the falling edge
	always @(negedge clk) begin : driver
		enc_item_t nxt;
		if (arst_n && !(in_valid && !in_taken)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (item_queue.size() > 0) begin
				nxt = item_queue.pop_front();
				{cmd, pin_a, pin_b, push_level, now_ms, modifier_held} <= nxt;
				in_valid <= 1'b1;
				in_gap = in_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (out_stall > 0) begin
			out_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Blocks until every queued item is transferred and every event is back
	task automatic wait_drained();
		do
			@(posedge clk);
		while (item_queue.size() > 0 || in_valid || pending_events.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Pin sample; the poll-only fields carry noise
	task automatic add_sample(input logic a, input logic b);
		enc_item_t it;
		it.cmd           = CMD_SAMPLE;
		it.pin_a         = a;
		it.pin_b         = b;
		it.push_level    = 1'($urandom_range(0, 1));
		it.now_ms        = $urandom;
		it.modifier_held = 1'($urandom_range(0, 1));
		item_queue.push_back(it);
		items_made++;
	endtask

	// Poll; the pin fields carry noise
	task automatic add_poll(input logic push, input logic [TIME_W-1:0] t_ms, input logic modif);
		enc_item_t it;
		it.cmd           = CMD_POLL;
		it.pin_a         = 1'($urandom_range(0, 1));
		it.pin_b         = 1'($urandom_range(0, 1));
		it.push_level    = push;
		it.now_ms        = t_ms;
		it.modifier_held = modif;
		item_queue.push_back(it);
		items_made++;
	endtask

	// One full detent as {b, a} levels; jitter adds contact bounce and lost edges
	task automatic add_turn(input bit cw, input bit jitter);
		logic [1:0] seq [4];
		if (cw)
			seq = '{2'b01, 2'b00, 2'b10, 2'b11};
		else
			seq = '{2'b10, 2'b00, 2'b01, 2'b11};
		for (int k = 0; k < 4; k++) begin
			if (jitter && k < 3 && $urandom_range(0, 9) == 0)
				continue;
			add_sample(seq[k][0], seq[k][1]);
			if (jitter && k < 3 && $urandom_range(0, 4) == 0)
				add_sample(seq[k][0], seq[k][1]);
		end
	endtask

	// Mostly whole detents and polls, with some pin noise
	task automatic add_random(input int n, input int deb);
		int target;
		int pick;
		target = items_made + n;
		while (items_made < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				repeat ($urandom_range(1, 2))
					add_turn(1'($urandom_range(0, 1)), 1'b1);
			end else if (pick < 85) begin
				if ($urandom_range(0, 7) == 0)
					clock_ms = $urandom;
				else
					clock_ms += $urandom_range(0, 2 * deb + 40);
				add_poll(1'($urandom_range(0, 1)), clock_ms, 1'($urandom_range(0, 1)));
			end else begin
				add_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin : stimulus
		int lim_r;
		int deb_r;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: every event kind, debounce boundary and time wrap
		add_poll(BTN_RELEASED, 32'd0, 1'b0);
		add_turn(1'b1, 1'b0);
		add_poll(BTN_RELEASED, 32'd5, 1'b0);
		add_turn(1'b0, 1'b0);
		add_poll(BTN_RELEASED, 32'd6, 1'b1);
		add_sample(1'b1, 1'b1);
		add_poll(BTN_PRESSED, 32'd31, 1'b0);
		add_turn(1'b1, 1'b0);
		// exactly the debounce time: release not yet taken
		add_poll(BTN_RELEASED, 32'd61, 1'b1);
		add_turn(1'b0, 1'b0);
		// release taken, same poll drains a detent
		add_poll(BTN_RELEASED, 32'd62, 1'b0);
		add_poll(BTN_PRESSED, 32'hFFFF_FFF0, 1'b0);
		// elapsed time wraps past zero
		add_poll(BTN_RELEASED, 32'h0000_0010, 1'b1);

		// Zero limit, zero debounce; writes to unused indexes must be dropped
		wait_drained();
		cfg_write(CFG_DETENT_LIMIT, 16'd0);
		cfg_write(CFG_DEBOUNCE_MS, 16'd0);
		cfg_write(CFG_IDX_SPARE_2, 16'hFFFF);
		cfg_write(CFG_IDX_SPARE_3, 16'h5A5A);
		add_turn(1'b1, 1'b0);
		add_poll(BTN_RELEASED, 32'h20, 1'b0);
		add_turn(1'b0, 1'b0);
		add_poll(BTN_RELEASED, 32'h21, 1'b1);
		add_poll(BTN_PRESSED, 32'h10, 1'b0);
		add_poll(BTN_PRESSED, 32'h11, 1'b0);
		clock_ms = 32'h11;
		add_random(40, 0);

		// Widest limit, longest debounce: store ten clockwise detents
		wait_drained();
		cfg_write(CFG_DETENT_LIMIT, 16'd127);
		cfg_write(CFG_DEBOUNCE_MS, 16'hFFFF);
		out_idle_on = 1'b0;
		repeat (10) add_turn(1'b1, 1'b0);

		// Limit lowered below the stored count
		wait_drained();
		cfg_write(CFG_DETENT_LIMIT, 16'd3);
		out_idle_on = 1'b1;
		add_turn(1'b1, 1'b0);
		add_turn(1'b0, 1'b0);
		repeat (3) add_poll(1'($urandom_range(0, 1)), clock_ms, 1'($urandom_range(0, 1)));
		add_random(80, 65535);

		// Back-to-back stretch, limit of one
		wait_drained();
		cfg_write(CFG_DETENT_LIMIT, 16'd1);
		cfg_write(CFG_DEBOUNCE_MS, 16'd5);
		in_idle_on  = 1'b0;
		out_idle_on = 1'b0;
		add_random(90, 5);

		// Random settings, receiver stalls only
		wait_drained();
		lim_r = $urandom_range(1, 127);
		deb_r = $urandom_range(0, 100);
		cfg_write(CFG_DETENT_LIMIT, CFG_DATA_W'(lim_r));
		cfg_write(CFG_DEBOUNCE_MS, CFG_DATA_W'(deb_r));
		out_idle_on = 1'b1;
		add_random(90, deb_r);

		wait_drained();
		cfg_write(CFG_DETENT_LIMIT, 16'd127);
		cfg_write(CFG_DEBOUNCE_MS, 16'd30);
		in_idle_on = 1'b1;
		add_random(90, 30);

		wait_drained();
		cfg_write(CFG_DETENT_LIMIT, 16'd2);
		cfg_write(CFG_DEBOUNCE_MS, 16'd1);
		add_random(80, 1);

		wait_drained();
		if (err_count == 0)
			$display("PASS rotary_encoder_detent_decoder");
		else
			$display("FAIL rotary_encoder_detent_decoder");
		$finish;
	end

	// Run limit
	initial begin
		#3_000_000;
		$display("FAIL rotary_encoder_detent_decoder");
		$finish;
	end

endmodule

[rotary_encoder_detent_decoder.f]
src/renc_pkg.sv
src/rotary_encoder_detent_decoder.sv
src/renc_checker.sv
dv/tb_rotary_encoder_detent_decoder.sv
